@@ rtl/assert_macros.svh @@
// Assertion helpers; bodies vanish under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define CPPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset.
`define CPPD_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPPD_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/cppd_pkg.sv @@
package cppd_pkg;

    // Q8.24 constants
    localparam logic signed [31:0] Q_ONE   = 32'sh0100_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    // Divider: one quotient bit per stage
    localparam int DIV_STEPS = 32;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENT_P1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENT_P2 = 3'd6;

    // Value with saturation flag
    typedef struct packed {
        logic              sat;
        logic signed [31:0] v;
    } t_qval;

    typedef struct packed {
        logic              sat;
        logic signed [15:0] v;
    } t_pix;

    // Distortion coefficients
    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    // Sideband flags traveling with a division
    typedef struct packed {
        logic q_neg;
        logic ovf;
        logic den_zero;
        logic num_zero;
    } t_dside;

    // Product / 2^24 truncated toward zero, clamped to 32 bits
    function automatic t_qval qtrunc(input logic signed [63:0] p);
        logic signed [63:0] adj;
        logic signed [39:0] s;
        t_qval r;
        adj = p[63] ? p + 64'sd16777215 : p;
        s = 40'(adj >>> 24);
        r.sat = 1'b0;
        if (s > 40'(S32_MAX)) begin
            r.sat = 1'b1;
            r.v = S32_MAX;
        end else if (s < 40'(S32_MIN)) begin
            r.sat = 1'b1;
            r.v = S32_MIN;
        end else begin
            r.v = 32'(s);
        end
        return r;
    endfunction

    // Clamp an exact sum to 32 bits
    function automatic t_qval sat32(input logic signed [35:0] s);
        t_qval r;
        r.sat = 1'b0;
        if (s > 36'(S32_MAX)) begin
            r.sat = 1'b1;
            r.v = S32_MAX;
        end else if (s < 36'(S32_MIN)) begin
            r.sat = 1'b1;
            r.v = S32_MIN;
        end else begin
            r.v = 32'(s);
        end
        return r;
    endfunction

    // Signed quotient from magnitude and flags
    function automatic t_qval div_fix(input logic [31:0] q, input t_dside sd);
        t_qval r;
        r.sat = 1'b0;
        r.v = '0;
        if (sd.den_zero) begin
            r.sat = 1'b1;
            if (sd.num_zero) r.v = '0;
            else r.v = sd.q_neg ? S32_MIN : S32_MAX;
        end else if (sd.num_zero) begin
            r.v = '0;
        end else if (sd.ovf) begin
            r.sat = 1'b1;
            r.v = sd.q_neg ? S32_MIN : S32_MAX;
        end else if (sd.q_neg) begin
            if (q > 32'h8000_0000) begin
                r.sat = 1'b1;
                r.v = S32_MIN;
            end else begin
                r.v = $signed(~q + 32'd1);
            end
        end else if (q[31]) begin
            r.sat = 1'b1;
            r.v = S32_MAX;
        end else begin
            r.v = $signed(q);
        end
        return r;
    endfunction

    // Pixel: value / 2^25 truncated toward zero, clamped to 16 bits
    function automatic t_pix pix_fix(input logic signed [47:0] p);
        logic signed [47:0] adj;
        logic signed [22:0] s;
        t_pix r;
        adj = p[47] ? p + 48'sd33554431 : p;
        s = 23'(adj >>> 25);
        r.sat = 1'b0;
        if (s > 23'sd32767) begin
            r.sat = 1'b1;
            r.v = 16'sh7FFF;
        end else if (s < -23'sd32768) begin
            r.sat = 1'b1;
            r.v = 16'sh8000;
        end else begin
            r.v = 16'(s);
        end
        return r;
    endfunction

endpackage

@@ rtl/cppd_div.sv @@
// Pipelined restoring divider: 64 / 32 unsigned, low 32 quotient bits.
// One quotient bit per stage; the caller flags quotient overflow.
module cppd_div #(
    parameter int SIDE_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_vld,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import cppd_pkg::*;

    logic              r_vld  [0:DIV_STEPS];
    logic [31:0]       r_rem  [0:DIV_STEPS];
    logic [31:0]       r_lo   [0:DIV_STEPS];
    logic [31:0]       r_quo  [0:DIV_STEPS];
    logic [31:0]       r_den  [0:DIV_STEPS];
    logic [SIDE_W-1:0] r_side [0:DIV_STEPS];

    // Load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
        if (i_ce) begin
            r_rem[0]  <= i_num[63:32];
            r_lo[0]   <= i_num[31:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // One compare and subtract per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0] n_sh;
        logic        n_ge;
        logic [32:0] n_diff;
        always_comb begin
            n_sh   = {r_rem[k], r_lo[k][31]};
            n_ge   = n_sh >= {1'b0, r_den[k]};
            n_diff = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_ce) begin
                r_rem[k+1]  <= n_ge ? n_diff[31:0] : n_sh[31:0];
                r_lo[k+1]   <= {r_lo[k][30:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][30:0], n_ge};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS];
    assign o_quo  = r_quo[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];

endmodule

@@ rtl/cppd_distort.sv @@
// Radial and tangential distortion, 13 register stages.
// Each multiply stage is followed by a truncation stage.
module cppd_distort (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_vld,
    input  logic                 i_front,
    input  logic                 i_sat,
    input  logic signed [31:0]   i_xn,
    input  logic signed [31:0]   i_yn,
    input  cppd_pkg::t_coef      i_coef,
    output logic                 o_vld,
    output logic                 o_front,
    output logic                 o_sat,
    output logic signed [31:0]   o_xt,
    output logic signed [31:0]   o_yt
);
    import cppd_pkg::*;

    localparam int NS = 13;

    logic r_vld   [1:NS];
    logic r_front [1:NS];
    logic r_sat   [1:NS];
    logic n_sat   [1:NS];

    logic signed [63:0] r1_xx, r1_yy, r1_xy;
    logic signed [31:0] r1_xn, r1_yn;
    logic signed [31:0] r2_x2, r2_y2, r2_xy, r2_xn, r2_yn;
    logic signed [31:0] r3_r2, r3_x2, r3_y2, r3_xy, r3_xn, r3_yn;
    logic signed [63:0] r4_rr, r4_k1p, r4_p1xyp, r4_p2xyp;
    logic signed [31:0] r4_xa, r4_ya, r4_r2, r4_xn, r4_yn;
    logic signed [31:0] r5_r4, r5_k1r2, r5_p1xy, r5_p2xy, r5_xa, r5_ya, r5_r2, r5_xn, r5_yn;
    logic signed [63:0] r6_r6p, r6_k2p, r6_p2xap, r6_p1yap;
    logic signed [31:0] r6_k1r2, r6_p1xy, r6_p2xy, r6_xn, r6_yn;
    logic signed [31:0] r7_r6, r7_k2r4, r7_p2xa, r7_p1ya;
    logic signed [31:0] r7_k1r2, r7_p1xy, r7_p2xy, r7_xn, r7_yn;
    logic signed [63:0] r8_k3p;
    logic signed [31:0] r8_k1r2, r8_k2r4, r8_p2xa, r8_p1ya, r8_p1xy, r8_p2xy, r8_xn, r8_yn;
    logic signed [31:0] r9_k3r6, r9_k1r2, r9_k2r4, r9_p2xa, r9_p1ya, r9_p1xy, r9_p2xy;
    logic signed [31:0] r9_xn, r9_yn;
    logic signed [31:0] r10_fac, r10_p2xa, r10_p1ya, r10_p1xy, r10_p2xy, r10_xn, r10_yn;
    logic signed [63:0] r11_xrp, r11_yrp;
    logic signed [31:0] r11_p2xa, r11_p1ya, r11_p1xy, r11_p2xy;
    logic signed [31:0] r12_xr, r12_yr, r12_p2xa, r12_p1ya, r12_p1xy, r12_p2xy;
    logic signed [31:0] r13_xt, r13_yt;

    t_qval q_x2, q_y2, q_xy, q_r2, q_xa, q_ya;
    t_qval q_r4, q_k1r2, q_p1xy, q_p2xy;
    t_qval q_r6, q_k2r4, q_p2xa, q_p1ya;
    t_qval q_k3r6, q_fac, q_xr, q_yr, q_xt, q_yt;

    // Truncations, clamped sums and saturation accumulation
    always_comb begin
        q_x2   = qtrunc(r1_xx);
        q_y2   = qtrunc(r1_yy);
        q_xy   = qtrunc(r1_xy);
        q_r2   = sat32(36'(r2_x2) + 36'(r2_y2));
        q_xa   = sat32(36'(r3_r2) + (36'(r3_x2) <<< 1));
        q_ya   = sat32(36'(r3_r2) + (36'(r3_y2) <<< 1));
        q_r4   = qtrunc(r4_rr);
        q_k1r2 = qtrunc(r4_k1p);
        q_p1xy = qtrunc(r4_p1xyp);
        q_p2xy = qtrunc(r4_p2xyp);
        q_r6   = qtrunc(r6_r6p);
        q_k2r4 = qtrunc(r6_k2p);
        q_p2xa = qtrunc(r6_p2xap);
        q_p1ya = qtrunc(r6_p1yap);
        q_k3r6 = qtrunc(r8_k3p);
        q_fac  = sat32(36'(Q_ONE) + 36'(r9_k1r2) + 36'(r9_k2r4) + 36'(r9_k3r6));
        q_xr   = qtrunc(r11_xrp);
        q_yr   = qtrunc(r11_yrp);
        q_xt   = sat32(36'(r12_xr) + (36'(r12_p1xy) <<< 1) + 36'(r12_p2xa));
        q_yt   = sat32(36'(r12_yr) + 36'(r12_p1ya) + (36'(r12_p2xy) <<< 1));

        n_sat[1]  = i_sat;
        n_sat[2]  = r_sat[1] | q_x2.sat | q_y2.sat | q_xy.sat;
        n_sat[3]  = r_sat[2] | q_r2.sat;
        n_sat[4]  = r_sat[3] | q_xa.sat | q_ya.sat;
        n_sat[5]  = r_sat[4] | q_r4.sat | q_k1r2.sat | q_p1xy.sat | q_p2xy.sat;
        n_sat[6]  = r_sat[5];
        n_sat[7]  = r_sat[6] | q_r6.sat | q_k2r4.sat | q_p2xa.sat | q_p1ya.sat;
        n_sat[8]  = r_sat[7];
        n_sat[9]  = r_sat[8] | q_k3r6.sat;
        n_sat[10] = r_sat[9] | q_fac.sat;
        n_sat[11] = r_sat[10];
        n_sat[12] = r_sat[11] | q_xr.sat | q_yr.sat;
        n_sat[13] = r_sat[12] | q_xt.sat | q_yt.sat;
    end

    // Valid and in-front bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_ce) begin
            r_vld[1] <= i_vld;
            for (int k = 2; k <= NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_front[1] <= i_front;
            for (int k = 2; k <= NS; k++) begin
                r_front[k] <= r_front[k-1];
            end
            for (int k = 1; k <= NS; k++) begin
                r_sat[k] <= n_sat[k];
            end
            // squares and cross term
            r1_xx <= i_xn * i_xn;
            r1_yy <= i_yn * i_yn;
            r1_xy <= i_xn * i_yn;
            r1_xn <= i_xn;
            r1_yn <= i_yn;
            r2_x2 <= q_x2.v;
            r2_y2 <= q_y2.v;
            r2_xy <= q_xy.v;
            r2_xn <= r1_xn;
            r2_yn <= r1_yn;
            // r2
            r3_r2 <= q_r2.v;
            r3_x2 <= r2_x2;
            r3_y2 <= r2_y2;
            r3_xy <= r2_xy;
            r3_xn <= r2_xn;
            r3_yn <= r2_yn;
            // r2^2, k1 term, tangential cross terms
            r4_rr    <= r3_r2 * r3_r2;
            r4_k1p   <= i_coef.k1 * r3_r2;
            r4_p1xyp <= i_coef.p1 * r3_xy;
            r4_p2xyp <= i_coef.p2 * r3_xy;
            r4_xa    <= q_xa.v;
            r4_ya    <= q_ya.v;
            r4_r2    <= r3_r2;
            r4_xn    <= r3_xn;
            r4_yn    <= r3_yn;
            r5_r4    <= q_r4.v;
            r5_k1r2  <= q_k1r2.v;
            r5_p1xy  <= q_p1xy.v;
            r5_p2xy  <= q_p2xy.v;
            r5_xa    <= r4_xa;
            r5_ya    <= r4_ya;
            r5_r2    <= r4_r2;
            r5_xn    <= r4_xn;
            r5_yn    <= r4_yn;
            // r2^3, k2 term, tangential square terms
            r6_r6p   <= r5_r4 * r5_r2;
            r6_k2p   <= i_coef.k2 * r5_r4;
            r6_p2xap <= i_coef.p2 * r5_xa;
            r6_p1yap <= i_coef.p1 * r5_ya;
            r6_k1r2  <= r5_k1r2;
            r6_p1xy  <= r5_p1xy;
            r6_p2xy  <= r5_p2xy;
            r6_xn    <= r5_xn;
            r6_yn    <= r5_yn;
            r7_r6    <= q_r6.v;
            r7_k2r4  <= q_k2r4.v;
            r7_p2xa  <= q_p2xa.v;
            r7_p1ya  <= q_p1ya.v;
            r7_k1r2  <= r6_k1r2;
            r7_p1xy  <= r6_p1xy;
            r7_p2xy  <= r6_p2xy;
            r7_xn    <= r6_xn;
            r7_yn    <= r6_yn;
            // k3 term
            r8_k3p   <= i_coef.k3 * r7_r6;
            r8_k1r2  <= r7_k1r2;
            r8_k2r4  <= r7_k2r4;
            r8_p2xa  <= r7_p2xa;
            r8_p1ya  <= r7_p1ya;
            r8_p1xy  <= r7_p1xy;
            r8_p2xy  <= r7_p2xy;
            r8_xn    <= r7_xn;
            r8_yn    <= r7_yn;
            r9_k3r6  <= q_k3r6.v;
            r9_k1r2  <= r8_k1r2;
            r9_k2r4  <= r8_k2r4;
            r9_p2xa  <= r8_p2xa;
            r9_p1ya  <= r8_p1ya;
            r9_p1xy  <= r8_p1xy;
            r9_p2xy  <= r8_p2xy;
            r9_xn    <= r8_xn;
            r9_yn    <= r8_yn;
            // radial factor
            r10_fac  <= q_fac.v;
            r10_p2xa <= r9_p2xa;
            r10_p1ya <= r9_p1ya;
            r10_p1xy <= r9_p1xy;
            r10_p2xy <= r9_p2xy;
            r10_xn   <= r9_xn;
            r10_yn   <= r9_yn;
            // radial scaling
            r11_xrp  <= r10_xn * r10_fac;
            r11_yrp  <= r10_yn * r10_fac;
            r11_p2xa <= r10_p2xa;
            r11_p1ya <= r10_p1ya;
            r11_p1xy <= r10_p1xy;
            r11_p2xy <= r10_p2xy;
            r12_xr   <= q_xr.v;
            r12_yr   <= q_yr.v;
            r12_p2xa <= r11_p2xa;
            r12_p1ya <= r11_p1ya;
            r12_p1xy <= r11_p1xy;
            r12_p2xy <= r11_p2xy;
            // tangential sum
            r13_xt   <= q_xt.v;
            r13_yt   <= q_yt.v;
        end
    end

    assign o_vld   = r_vld[NS];
    assign o_front = r_front[NS];
    assign o_sat   = r_sat[NS];
    assign o_xt    = r13_xt;
    assign o_yt    = r13_yt;

endmodule

@@ rtl/camera_point_projection_distortion_unit.sv @@
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  forward, left, up
// m_axis    out  m_axis_tvalid/m_axis_tready  in_front, pixel_x, pixel_y, clipped
// cfg       in   i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// One point per cycle unless the output stall holds the pipeline. Points pass through
// input capture, magnitude and numerator stages, the 33-stage projection divider (load
// plus 32 quotient bits), the 13-stage distortion chain, pixel scaling and the output register.
// Synchronous active-low reset clears all valid bits and loads default registers.
// When the output register holds an untaken result, the whole pipeline holds.
`include "assert_macros.svh"
module camera_point_projection_distortion_unit #(
    parameter int FRAME_WIDTH  = cppd_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = cppd_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_wr_en,
    input  logic [cppd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // input points
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [95:0]                    s_axis_tdata,  // forward, left, up
    // output pixels
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata   // in_front, pixel_x, pixel_y,
                                                          // clipped, zero pad
);
    import cppd_pkg::*;

    localparam logic signed [47:0] C_W  = 48'(FRAME_WIDTH);
    localparam logic signed [47:0] C_HQ = 48'(FRAME_HEIGHT) <<< 24;

    localparam int XSIDE_W = $bits(t_dside) + 1;
    localparam int YSIDE_W = $bits(t_dside);

    logic w_ce;

    // Configuration registers
    logic [31:0] r_focal_x, r_focal_y;
    t_coef       r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= 32'(Q_ONE);
            r_focal_y <= 32'(Q_ONE);
            r_coef    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FOCAL_X:    r_focal_x <= i_cfg_data;
                REG_FOCAL_Y:    r_focal_y <= i_cfg_data;
                REG_RADIAL_K1:  r_coef.k1 <= $signed(i_cfg_data);
                REG_RADIAL_K2:  r_coef.k2 <= $signed(i_cfg_data);
                REG_RADIAL_K3:  r_coef.k3 <= $signed(i_cfg_data);
                REG_TANGENT_P1: r_coef.p1 <= $signed(i_cfg_data);
                REG_TANGENT_P2: r_coef.p2 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Global stall: hold everything while the output is not taken
    logic r_out_vld;
    assign w_ce          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_ce;

    // Stage 0: input capture; stage 1: magnitudes; stage 2: numerators
    logic               r0_vld, r1_vld, r2_vld;
    logic signed [31:0] r0_fwd, r0_lft, r0_up;
    logic [31:0]        r1_fwd_m, r1_lft_m, r1_up_m;
    logic               r1_front, r1_den_neg, r1_xneg, r1_yneg;
    logic [63:0]        r2_xnum, r2_ynum;
    logic [31:0]        r2_den;
    logic               r2_front, r2_den_neg, r2_xneg, r2_yneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_ce) begin
            r0_vld <= s_axis_tvalid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r0_fwd     <= $signed(s_axis_tdata[31:0]);
            r0_lft     <= $signed(s_axis_tdata[63:32]);
            r0_up      <= $signed(s_axis_tdata[95:64]);
            r1_fwd_m   <= r0_fwd[31] ? ~r0_fwd + 32'd1 : r0_fwd;
            r1_lft_m   <= r0_lft[31] ? ~r0_lft + 32'd1 : r0_lft;
            r1_up_m    <= r0_up[31] ? ~r0_up + 32'd1 : r0_up;
            r1_front   <= !r0_fwd[31];
            r1_den_neg <= r0_fwd[31];
            r1_xneg    <= r0_lft > 32'sd0;   // numerator is -left * focal_x
            r1_yneg    <= r0_up[31];
            r2_xnum    <= 64'(r1_lft_m) * 64'(r_focal_x);
            r2_ynum    <= 64'(r1_up_m) * 64'(r_focal_y);
            r2_den     <= r1_fwd_m;
            r2_front   <= r1_front;
            r2_den_neg <= r1_den_neg;
            r2_xneg    <= r1_xneg;
            r2_yneg    <= r1_yneg;
        end
    end

    // Division sideband flags
    t_dside w_xsd, w_ysd;
    always_comb begin
        w_xsd.q_neg    = r2_xneg ^ r2_den_neg;
        w_xsd.ovf      = r2_xnum[63:32] >= r2_den;
        w_xsd.den_zero = r2_den == '0;
        w_xsd.num_zero = r2_xnum == '0;
        w_ysd.q_neg    = r2_yneg ^ r2_den_neg;
        w_ysd.ovf      = r2_ynum[63:32] >= r2_den;
        w_ysd.den_zero = r2_den == '0;
        w_ysd.num_zero = r2_ynum == '0;
    end

    logic               w_xdiv_vld, w_ydiv_vld;
    logic [31:0]        w_xquo, w_yquo;
    logic [XSIDE_W-1:0] w_xside;
    logic [YSIDE_W-1:0] w_yside;

    cppd_div #(.SIDE_W(XSIDE_W)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r2_vld),
        .i_num  (r2_xnum),
        .i_den  (r2_den),
        .i_side ({r2_front, w_xsd}),
        .o_vld  (w_xdiv_vld),
        .o_quo  (w_xquo),
        .o_side (w_xside)
    );

    cppd_div #(.SIDE_W(YSIDE_W)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r2_vld),
        .i_num  (r2_ynum),
        .i_den  (r2_den),
        .i_side (w_ysd),
        .o_vld  (w_ydiv_vld),
        .o_quo  (w_yquo),
        .o_side (w_yside)
    );

    // Signed, saturated projection results
    t_qval w_xn, w_yn;
    always_comb begin
        w_xn = div_fix(w_xquo, t_dside'(w_xside[YSIDE_W-1:0]));
        w_yn = div_fix(w_yquo, t_dside'(w_yside));
    end

    logic               r4_vld, r4_front, r4_sat;
    logic signed [31:0] r4_xn, r4_yn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_ce) begin
            r4_vld <= w_xdiv_vld & w_ydiv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_front <= w_xside[XSIDE_W-1];
            r4_sat   <= w_xn.sat | w_yn.sat;
            r4_xn    <= w_xn.v;
            r4_yn    <= w_yn.v;
        end
    end

    logic               w_dst_vld, w_dst_front, w_dst_sat;
    logic signed [31:0] w_xt, w_yt;

    cppd_distort u_distort (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r4_vld),
        .i_front(r4_front),
        .i_sat  (r4_sat),
        .i_xn   (r4_xn),
        .i_yn   (r4_yn),
        .i_coef (r_coef),
        .o_vld  (w_dst_vld),
        .o_front(w_dst_front),
        .o_sat  (w_dst_sat),
        .o_xt   (w_xt),
        .o_yt   (w_yt)
    );

    // Pixel scaling, then truncation into the output register
    logic               r5_vld, r5_front, r5_sat;
    logic signed [47:0] r5_px, r5_py;
    t_pix               w_px, w_py;

    always_comb begin
        w_px = pix_fix(r5_px);
        w_py = pix_fix(r5_py);
    end

    logic [39:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r5_vld    <= w_dst_vld;
            r_out_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r5_front   <= w_dst_front;
            r5_sat     <= w_dst_sat;
            r5_px      <= (48'(w_xt) + 48'(Q_ONE)) * C_W;
            r5_py      <= C_HQ - 48'(w_yt) * C_W;
            r_out_data <= {6'd0, r5_sat | w_px.sat | w_py.sat, w_py.v, w_px.v, r5_front};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Checks
    `CPPD_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input accepted during output stall")
    `CPPD_ASSERT(a_input_captured, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> r0_vld, "accepted point not captured")
    `CPPD_ASSERT_NORST(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

@@ tb/camera_point_projection_distortion_checker.sv @@
`timescale 1ns / 1ps

// Watches the point and pixel channels and the register port, predicts each
// pixel result and compares it against what the unit produces.
module camera_point_projection_distortion_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [cppd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // forward, left, up
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // in_front, pixel_x, pixel_y, clipped, pad
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_clipped
);
    import cppd_pkg::*;

    localparam longint ONE  = 64'sd16777216;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        bit              in_front;
        bit signed [15:0] px;
        bit signed [15:0] py;
        bit              clipped;
    } t_pixel;

    // shadow copy of the lens registers
    bit [31:0] fx, fy;
    bit signed [31:0] k1, k2, k3, p1, p2;

    t_pixel pixel_q[$];

    function automatic longint lim(longint v, longint lo, longint hi, inout bit sat);
        if (v > hi) begin
            sat = 1;
            return hi;
        end
        if (v < lo) begin
            sat = 1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint fmul(longint a, longint b, inout bit sat);
        return lim((a * b) / ONE, SMIN, SMAX, sat);
    endfunction

    function automatic longint persp(longint num, longint den, inout bit sat);
        if (den == 0) begin
            sat = 1;
            return (num > 0) ? SMAX : (num < 0) ? SMIN : 0;
        end
        return lim(num / den, SMIN, SMAX, sat);
    endfunction

    // project one camera-frame point and apply lens distortion
    function automatic t_pixel project_point(bit signed [31:0] fwd,
                                             bit signed [31:0] lft,
                                             bit signed [31:0] upv);
        bit sat;
        longint xn, yn, x2, y2, xy, r2, r4, r6, fac, xr, yr, xa, ya, xt, yt, px, py;
        t_pixel r;
        sat = 0;
        xn = persp(-longint'(lft) * longint'(fx), longint'(fwd), sat);
        yn = persp(longint'(upv) * longint'(fy), longint'(fwd), sat);
        x2 = fmul(xn, xn, sat);
        y2 = fmul(yn, yn, sat);
        xy = fmul(xn, yn, sat);
        r2 = lim(x2 + y2, SMIN, SMAX, sat);
        r4 = fmul(r2, r2, sat);
        r6 = fmul(r4, r2, sat);
        fac = lim(ONE + fmul(k1, r2, sat) + fmul(k2, r4, sat) + fmul(k3, r6, sat),
                  SMIN, SMAX, sat);
        xr = fmul(xn, fac, sat);
        yr = fmul(yn, fac, sat);
        xa = lim(r2 + 2 * x2, SMIN, SMAX, sat);
        ya = lim(r2 + 2 * y2, SMIN, SMAX, sat);
        xt = lim(xr + 2 * fmul(p1, xy, sat) + fmul(p2, xa, sat), SMIN, SMAX, sat);
        yt = lim(yr + fmul(p1, ya, sat) + 2 * fmul(p2, xy, sat), SMIN, SMAX, sat);
        px = ((xt + ONE) * 640) / (2 * ONE);
        py = (480 * ONE - yt * 640) / (2 * ONE);
        px = lim(px, -32768, 32767, sat);
        py = lim(py, -32768, 32767, sat);
        r.in_front = (fwd >= 0);
        r.px = px[15:0];
        r.py = py[15:0];
        r.clipped = sat;
        return r;
    endfunction

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_pixel e, a;
        int n_err;
        n_err = 0;
        if (!i_rst_n) begin
            fx <= 32'h0100_0000;
            fy <= 32'h0100_0000;
            {k1, k2, k3, p1, p2} <= '0;
            pixel_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_clipped <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_FOCAL_X:    fx <= i_cfg_data;
                    REG_FOCAL_Y:    fy <= i_cfg_data;
                    REG_RADIAL_K1:  k1 <= i_cfg_data;
                    REG_RADIAL_K2:  k2 <= i_cfg_data;
                    REG_RADIAL_K3:  k3 <= i_cfg_data;
                    REG_TANGENT_P1: p1 <= i_cfg_data;
                    REG_TANGENT_P2: p2 <= i_cfg_data;
                    default: ;
                endcase
            end
            // point transaction: queue its expected pixel
            if (s_axis_tvalid && s_axis_tready)
                pixel_q = {pixel_q, project_point(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                  s_axis_tdata[95:64])};
            // pixel transaction: compare with the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                a.in_front = m_axis_tdata[0];
                a.px = m_axis_tdata[16:1];
                a.py = m_axis_tdata[32:17];
                a.clipped = m_axis_tdata[33];
                o_results <= o_results + 1;
                if (pixel_q.size() == 0) begin
                    $error("pixel transaction with nothing expected");
                    n_err++;
                end else begin
                    e = pixel_q.pop_front();
                    if (e.clipped) o_clipped <= o_clipped + 1;
                    if (a.in_front != e.in_front) begin
                        $error("in_front: expected %0d got %0d", e.in_front, a.in_front);
                        n_err++;
                    end
                    if (a.px != e.px) begin
                        $error("pixel_x: expected %0d got %0d", e.px, a.px);
                        n_err++;
                    end
                    if (a.py != e.py) begin
                        $error("pixel_y: expected %0d got %0d", e.py, a.py);
                        n_err++;
                    end
                    if (a.clipped != e.clipped) begin
                        $error("clipped: expected %0d got %0d", e.clipped, a.clipped);
                        n_err++;
                    end
                end
            end
            o_errors <= o_errors + n_err;
        end
    end
endmodule

@@ tb/tb_camera_point_projection_distortion_unit.sv @@
`timescale 1ns / 1ps

module tb_camera_point_projection_distortion_unit;
    import cppd_pkg::*;

    localparam int LATENCY_WAIT = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int METER        = 65536;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // forward, left, up
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // in_front, pixel_x, pixel_y, clipped, pad

    int errors, pending, results, clipped_cnt;
    int send_idle_pct, recv_stall_pct;
    int cycles = 0;
    int points_sent;
    bit hold_req;
    bit hold_done;

    camera_point_projection_distortion_unit uut (.*);

    camera_point_projection_distortion_checker chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_clipped(clipped_cnt)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_camera_point_projection_distortion_unit NOT OK");
            $finish;
        end
    end

    // pixel receiver: random stalls plus one long hold-off on request
    initial begin
        m_axis_tready = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done && i_rst_n) begin
                m_axis_tready <= 0;
                repeat (400) @(negedge i_clk);
                hold_done = 1;
            end
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_point(bit [31:0] fwd, bit [31:0] lft, bit [31:0] upv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {upv, lft, fwd};
        do @(posedge i_clk); while (!s_axis_tready);
        points_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic load_lens(bit [31:0] fxv, bit [31:0] fyv, bit [31:0] a, bit [31:0] b,
                             bit [31:0] c, bit [31:0] d, bit [31:0] e);
        write_reg(REG_FOCAL_X, fxv);
        write_reg(REG_FOCAL_Y, fyv);
        write_reg(REG_RADIAL_K1, a);
        write_reg(REG_RADIAL_K2, b);
        write_reg(REG_RADIAL_K3, c);
        write_reg(REG_TANGENT_P1, d);
        write_reg(REG_TANGENT_P2, e);
        i_cfg_wr_en <= 0;
    endtask

    // quiet the point channel and let the pipeline drain
    task automatic drain;
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    function automatic bit [31:0] srand_range(int mag);
        return $urandom_range(2 * mag) - mag;
    endfunction

    // mostly plausible scene points, some raw bit patterns
    task automatic random_points(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 7)
                send_point($urandom_range(60 * METER, METER / 4),
                           srand_range(30 * METER), srand_range(20 * METER));
            else if ($urandom_range(1))
                send_point(srand_range(4 * METER), srand_range(8 * METER),
                           srand_range(8 * METER));
            else
                send_point($urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_lens;
        load_lens($urandom_range(32'h0200_0000, 32'h0040_0000),
                  $urandom_range(32'h0200_0000, 32'h0040_0000),
                  srand_range(32'h0060_0000), srand_range(32'h0020_0000),
                  srand_range(32'h0010_0000), srand_range(32'h0004_0000),
                  srand_range(32'h0004_0000));
    endtask

    initial begin
        points_sent = 0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: reset lens, zero depth, field extremes, behind camera
        send_point(0, METER, METER);
        send_point(0, -METER, -METER);
        send_point(0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 0, 0);
        send_point(1, 32'h8000_0000, 32'h8000_0000);
        send_point(-1, 1, -1);
        send_point(-10 * METER, 2 * METER, 3 * METER);
        send_point(10 * METER, 2 * METER, -3 * METER);
        send_point(METER, METER, METER);
        send_point(METER, 0, 0);
        send_point(METER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // extreme lens: largest focal and coefficients
        load_lens(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(METER, 0, 0);
        send_point(METER, METER / 8, METER / 8);
        send_point(5 * METER, -METER, METER);
        send_point(0, METER, 0);
        drain();

        // opposite extremes: zero focal, most negative coefficients
        load_lens(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
        send_point(METER, METER, METER);
        send_point(2 * METER, -3 * METER, 4 * METER);
        send_point(0, 0, METER);
        drain();

        // random phases, one idling style each
        for (int ph = 0; ph < 8; ph++) begin
            random_lens();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 4) hold_req = 1;
            random_points(75);
            drain();
        end

        $display("%0d points sent, %0d pixel results checked, %0d with clipping,",
                 points_sent, results, clipped_cnt);
        $display("over 11 lens settings and four handshake idling styles");
        if (errors == 0)
            $display("tb_camera_point_projection_distortion_unit OK");
        else
            $display("tb_camera_point_projection_distortion_unit NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cppd_pkg.sv
rtl/cppd_div.sv
rtl/cppd_distort.sv
rtl/camera_point_projection_distortion_unit.sv
tb/camera_point_projection_distortion_checker.sv
tb/tb_camera_point_projection_distortion_unit.sv
